// File: design/sha256_hash_engine_top_defines.svh
// assertion macros for the sha-256 engine checker
`ifndef SHA256_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA256_HASH_ENGINE_TOP_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define SHA_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sha256 check failed");

// consequent must hold on the edge after the antecedent
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sha256 check failed");

`endif

// File: design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// types, constants and round functions shared by the sha-256 engine
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PADZ,
    ST_OUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic take_byte;   // write byte into buffer, bump count
    logic start_blk;   // load working regs from chain
    logic do_round;    // one compression round
    logic add_chain;   // add working regs into chain
    logic pad_byte;    // write one pad byte at the fill pointer
    logic len_write;   // place length in last 8 bytes of buffer
    logic restart;     // reload iv, clear count
  } sha_cmd_t;

  // status back to controller
  typedef struct packed {
    logic blk_full;    // count low 6 bits wrap on this byte
    logic last_round;  // round 63 running
    logic [5:0] fill;  // buffer fill pointer
  } sha_sts_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// File: design/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer: byte intake, block compression, padding and digest output
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_has_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  sha_pkg::sha_sts_t sts_i,
  output sha_pkg::sha_cmd_t cmd_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_idx_o
);
  import sha_pkg::*;

  state_e state_q, state_d;
  logic       fin_q, fin_d;     // padding in progress for this message
  logic       lenpl_q, lenpl_d; // length block pending
  logic [2:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
      lenpl_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      lenpl_q <= lenpl_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    lenpl_d    = lenpl_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_has_i) cmd_o.take_byte = 1'b1;
          if (in_has_i && sts_i.blk_full) begin
            cmd_o.start_blk = 1'b1;
            fin_d   = in_last_i;
            lenpl_d = in_last_i;
            state_d = ST_ROUND;
          end else if (in_last_i) begin
            fin_d   = 1'b1;
            lenpl_d = 1'b1;
            state_d = ST_PADZ;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.do_round = 1'b1;
        if (sts_i.last_round) state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_chain = 1'b1;
        if (!fin_q) state_d = ST_IDLE;
        else if (lenpl_q) state_d = ST_PADZ;
        else begin
          idx_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_PADZ: begin
        // first pad byte is 0x80, then zeros; the padf flag drives the choice
        cmd_o.pad_byte = 1'b1;
        if (sts_i.fill == 6'd55) begin
          cmd_o.len_write = 1'b1;
          cmd_o.start_blk = 1'b1;
          lenpl_d = 1'b0;
          state_d = ST_ROUND;
        end else if (sts_i.fill == 6'd63) begin
          cmd_o.start_blk = 1'b1;
          state_d = ST_ROUND;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_idx_o = idx_q;

endmodule

// File: design/sha_dpath.sv
// ----------------------------------------------------------------------------
// sha_dpath
// schedule window doubling as block buffer, working regs, chain hash, count
// ----------------------------------------------------------------------------
module sha_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::sha_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  input  logic [2:0]        out_idx_i,
  output sha_pkg::sha_sts_t sts_o,
  output logic [31:0]       digest_word_o,
  output logic              too_long_o
);
  import sha_pkg::*;

  // bytes land big-endian in the window words, which then run as the schedule
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [60:0] cnt_q;
  logic        ovf_q;
  logic [5:0]  fill_q;   // pad write pointer
  logic        padf_q;   // next pad byte is the 0x80 marker
  logic [6:0]  rnd_q;
  logic [63:0] bits;
  logic [7:0]  pad_val;

  assign bits    = {cnt_q, 3'b000};
  assign pad_val = padf_q ? PadByte : 8'h00;

  // schedule word for this round
  logic [31:0] w_new, w_use, x15, x2, s0, s1;
  assign x15   = w_q[1];
  assign x2    = w_q[14];
  assign s0    = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
  assign s1    = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign w_use = (rnd_q < 7'd16) ? w_q[0] : w_new;

  logic [31:0] big0, big1, ch, maj, t1, t2;
  assign big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + RoundK[rnd_q[5:0]] + w_use;
  assign big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  // byte writes; during rounds the window is a shift line so w_q[0] is word r (word r-16 from round 16 on)
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) w_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] <= data_byte_i;
    if (cmd_i.pad_byte) w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= pad_val;
    if (cmd_i.len_write) begin
      w_q[14] <= bits[63:32];
      w_q[15] <= bits[31:0];
    end
    if (cmd_i.start_blk) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.do_round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_use;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      fill_q <= '0;
      padf_q <= 1'b1;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.take_byte) begin
        if (&cnt_q) ovf_q <= 1'b1;
        cnt_q  <= cnt_q + 61'd1;
        fill_q <= cnt_q[5:0] + 6'd1;
      end
      if (cmd_i.pad_byte) begin
        fill_q <= fill_q + 6'd1;
        padf_q <= 1'b0;
      end
      if (cmd_i.do_round) rnd_q <= rnd_q + 7'd1;
      else rnd_q <= '0;
      if (cmd_i.add_chain) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
        fill_q <= '0;
        padf_q <= 1'b1;
      end
    end
  end

  assign sts_o.blk_full   = (cnt_q[5:0] == 6'd63);
  assign sts_o.last_round = (rnd_q == 7'd63);
  assign sts_o.fill       = fill_q;
  assign digest_word_o    = h_q[out_idx_i];
  assign too_long_o       = ovf_q;

endmodule

// File: design/sha256_hash_engine_top.sv
// A message streams in at most one byte per request; a request with tlast ends it and
// eight digest words come out, most significant first. Each 64-byte block
// holds input off after its last byte is taken, while it runs 64 rounds in the
// single round unit and one chain add; padding writes one buffer byte per cycle.
// ----------------------------------------------------------------------------
// sha256_hash_engine_top
// sha-256 engine: sequencer plus round datapath
// ----------------------------------------------------------------------------
module sha256_hash_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word, word_index, too_long, zero fill
  output logic        m_axis_tlast    // final_word
);
  import sha_pkg::*;

  sha_cmd_t   cmd;
  sha_sts_t   sts;
  logic [2:0] idx;
  logic [31:0] word;
  logic        tl;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_has_i   (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_idx_o  (idx)
  );

  sha_dpath u_dpath (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .data_byte_i  (s_axis_tdata),
    .out_idx_i    (idx),
    .sts_o        (sts),
    .digest_word_o(word),
    .too_long_o   (tl)
  );

  assign m_axis_tdata = {4'b0000, tl, idx, word};
  assign m_axis_tlast = (idx == 3'd7);

endmodule

// File: design/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks on the sha-256 engine
// ----------------------------------------------------------------------------
`include "sha256_hash_engine_top_defines.svh"
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  logic [2:0] idx_w;
  assign idx_w = m_axis_tdata[34:32];

  // never take input while a digest is being shown
  `SHA_ASSERT_CLK(a_no_overlap, clk_i, rst_ni, !(m_axis_tvalid && s_axis_tready))
  // tlast marks word seven only
  `SHA_ASSERT_CLK(a_last_idx, clk_i, rst_ni, !m_axis_tvalid || (m_axis_tlast == (idx_w == 3'd7)))
  // words advance by one per taken request
  `SHA_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && idx_w == $past(idx_w) + 3'd1)
endmodule

bind sha256_hash_engine_top sha_checker u_sha_checker (.*);
